>>> design/hcs_pkg.sv
// ----------------------------------------------------------------------------
// hcs_pkg: shared types and constants for the horizon channel scheduler
// Request codes, field layout of the stream beats, configuration layout and
// the control bundle that moves from cell to cell along the chain.
// ----------------------------------------------------------------------------
package hcs_pkg;

  // Request codes carried in the command field
  typedef enum logic [1:0] {
    CMD_FIND   = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  // Input beat layout (fixed field widths)
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned PORT_W    = 2;
  localparam int unsigned CHAN_W    = 5;
  localparam int unsigned TIN_W     = 48;
  localparam int unsigned CMD_LSB   = 0;
  localparam int unsigned PORT_LSB  = CMD_LSB + CMD_W;
  localparam int unsigned CHAN_LSB  = PORT_LSB + PORT_W;
  localparam int unsigned TIN_LSB   = CHAN_LSB + CHAN_W;
  localparam int unsigned IN_BITS   = TIN_LSB + TIN_W;
  localparam int unsigned IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

  // Result beat layout (fixed field widths)
  localparam int unsigned CHOSEN_W   = 4;
  localparam int unsigned TOUT_W     = 48;
  localparam int unsigned FOUND_LSB  = 0;
  localparam int unsigned CHOSEN_LSB = FOUND_LSB + 1;
  localparam int unsigned TOUT_LSB   = CHOSEN_LSB + CHOSEN_W;
  localparam int unsigned OUT_BITS   = TOUT_LSB + TOUT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Configuration registers: one channel count per port
  localparam int unsigned CFG_NUM   = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Control bundle handed from one cell to the next
  typedef struct packed {
    logic              valid;  // beat present in this slot
    cmd_e              cmd;    // request code
    logic [PORT_W-1:0] port;   // port the request concerns
    logic [CHAN_W-1:0] chan;   // signed channel index, top bit set means none
    logic              ch_ok;  // channel and port both in range
    logic              have;   // find: a qualifying channel seen so far
  } ctl_t;

endpackage

>>> design/hcs_cell.sv
// ----------------------------------------------------------------------------
// hcs_cell: one channel slot of the scheduler chain
// Holds the horizon of one channel for every port. A request passes through
// one registered slot: a find compares against the running best gap, an
// update writes the horizon, a read picks up the stored value.
// ----------------------------------------------------------------------------
module hcs_cell #(
  parameter int unsigned NUM_PORTS  = 4,
  parameter int unsigned CHANNELS   = 16,
  parameter int unsigned TIME_WIDTH = 48,
  parameter int unsigned IDX        = 0,
  parameter int unsigned NW         = $clog2(CHANNELS + 1),
  parameter int unsigned CW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  hcs_pkg::ctl_t         ctl_i,
  input  logic [TIME_WIDTH-1:0] time_i,
  input  logic [NW-1:0]         used_i,
  input  logic [TIME_WIDTH-1:0] gap_i,
  input  logic [CW-1:0]         best_i,
  input  logic [TIME_WIDTH-1:0] rdhz_i,
  output hcs_pkg::ctl_t         ctl_o,
  output logic [TIME_WIDTH-1:0] time_o,
  output logic [NW-1:0]         used_o,
  output logic [TIME_WIDTH-1:0] gap_o,
  output logic [CW-1:0]         best_o,
  output logic [TIME_WIDTH-1:0] rdhz_o
);
  import hcs_pkg::*;

  localparam int unsigned PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  logic [TIME_WIDTH-1:0] hz_q [NUM_PORTS];

  ctl_t                  ctl_d, ctl_q;
  logic [TIME_WIDTH-1:0] time_q;
  logic [NW-1:0]         used_q;
  logic [TIME_WIDTH-1:0] gap_d, gap_q;
  logic [CW-1:0]         best_d, best_q;
  logic [TIME_WIDTH-1:0] rdhz_d, rdhz_q;

  logic [PW-1:0]         pidx;
  logic [TIME_WIDTH-1:0] hz_cur;
  logic [TIME_WIDTH-1:0] gap_cur;
  logic                  match;
  logic                  in_use;
  logic                  take;
  logic                  wr_en;

  // Select this channel's horizon for the requested port
  assign pidx   = PW'(ctl_i.port);
  assign hz_cur = hz_q[pidx];

  assign match  = ctl_i.ch_ok && !ctl_i.chan[CHAN_W-1] &&
                  (int'(ctl_i.chan[CHAN_W-2:0]) == IDX);
  assign in_use = NW'(IDX) < used_i;
  assign gap_cur = time_i - hz_cur;

  // Take this channel when it is free before arrival and closest so far
  assign take  = (ctl_i.cmd == CMD_FIND) && in_use && (time_i > hz_cur) &&
                 (!ctl_i.have || (gap_cur < gap_i));
  assign wr_en = adv_i && ctl_i.valid && (ctl_i.cmd == CMD_UPDATE) && match;

  always_comb begin
    ctl_d  = ctl_i;
    gap_d  = gap_i;
    best_d = best_i;
    rdhz_d = rdhz_i;
    if (take) begin
      ctl_d.have = 1'b1;
      gap_d      = gap_cur;
      best_d     = CW'(IDX);
    end
    if ((ctl_i.cmd == CMD_READ) && match) begin
      rdhz_d = hz_cur;
    end
  end

  // Horizon storage, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        hz_q[p] <= '0;
      end
    end else if (wr_en) begin
      hz_q[pidx] <= time_i;
    end
  end

  // Slot valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_d;
    end
  end

  // Slot payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      time_q <= time_i;
      used_q <= used_i;
      gap_q  <= gap_d;
      best_q <= best_d;
      rdhz_q <= rdhz_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign time_o = time_q;
  assign used_o = used_q;
  assign gap_o  = gap_q;
  assign best_o = best_q;
  assign rdhz_o = rdhz_q;

endmodule

>>> design/horizon_channel_scheduler_core.sv
// ----------------------------------------------------------------------------
// horizon_channel_scheduler_core: latest-available-unused-channel scheduler
// Throughput: one request per cycle, the cell chain moves as one pipeline and
// stalls as a whole while a result beat waits on the output.
// Reset: all horizons clear to zero, every port's channel count returns to 16,
// and the chain is empty.
// ----------------------------------------------------------------------------
module horizon_channel_scheduler_core #(
  parameter int unsigned NUM_PORTS  = 4,
  parameter int unsigned CHANNELS   = 16,
  parameter int unsigned TIME_WIDTH = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [hcs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [hcs_pkg::CFG_W-1:0]           cfg_wdata_i,
  // request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: command[1:0], port[3:2], channel[8:4], time_value[56:9], zeros above
  input  logic [hcs_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: found[0], chosen_channel[4:1], horizon_time[52:5], zeros above
  output logic [hcs_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import hcs_pkg::*;

  localparam int unsigned NW = $clog2(CHANNELS + 1);
  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CFG_W-1:0] cfg_q [CFG_NUM];

  ctl_t                  ctl_s  [CHANNELS+1];
  logic [TIME_WIDTH-1:0] time_s [CHANNELS+1];
  logic [NW-1:0]         used_s [CHANNELS+1];
  logic [TIME_WIDTH-1:0] gap_s  [CHANNELS+1];
  logic [CW-1:0]         best_s [CHANNELS+1];
  logic [TIME_WIDTH-1:0] rdhz_s [CHANNELS+1];

  logic              adv;
  logic [PORT_W-1:0] in_port;
  logic [CHAN_W-1:0] in_chan;
  logic [CFG_W-1:0]  cfg_sel;
  logic              port_ok;
  ctl_t              head_ctl;
  logic [NW-1:0]     head_used;
  ctl_t              tail;
  logic              found;
  logic              unused_tail;

  // Channel count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_NUM; i++) begin
        cfg_q[i] <= CFG_RESET;
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // Advance the whole chain unless a result beat is held at the tail
  assign adv           = !ctl_s[CHANNELS].valid || m_axis_tready;
  assign s_axis_tready = adv;

  // Decode the request into the head slot
  assign in_port = s_axis_tdata[PORT_LSB +: PORT_W];
  assign in_chan = s_axis_tdata[CHAN_LSB +: CHAN_W];
  assign cfg_sel = cfg_q[in_port];
  assign port_ok = int'(in_port) < NUM_PORTS;

  always_comb begin
    head_ctl.valid = s_axis_tvalid;
    head_ctl.cmd   = cmd_e'(s_axis_tdata[CMD_LSB +: CMD_W]);
    head_ctl.port  = in_port;
    head_ctl.chan  = in_chan;
    head_ctl.ch_ok = port_ok && !in_chan[CHAN_W-1] &&
                     (int'(in_chan[CHAN_W-2:0]) < CHANNELS);
    head_ctl.have  = 1'b0;
    // saturate the port's channel count to the channels built
    if (!port_ok) begin
      head_used = '0;
    end else if (int'(cfg_sel) > CHANNELS) begin
      head_used = NW'(CHANNELS);
    end else begin
      head_used = NW'(cfg_sel);
    end
  end

  assign ctl_s[0]  = head_ctl;
  assign time_s[0] = TIME_WIDTH'(s_axis_tdata[TIN_LSB +: TIN_W]);
  assign used_s[0] = head_used;
  assign gap_s[0]  = '0;
  assign best_s[0] = '0;
  assign rdhz_s[0] = '0;

  // One cell per channel, each one pipeline slot
  for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
    hcs_cell #(
      .NUM_PORTS  (NUM_PORTS),
      .CHANNELS   (CHANNELS),
      .TIME_WIDTH (TIME_WIDTH),
      .IDX        (g),
      .NW         (NW),
      .CW         (CW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctl_i  (ctl_s[g]),
      .time_i (time_s[g]),
      .used_i (used_s[g]),
      .gap_i  (gap_s[g]),
      .best_i (best_s[g]),
      .rdhz_i (rdhz_s[g]),
      .ctl_o  (ctl_s[g+1]),
      .time_o (time_s[g+1]),
      .used_o (used_s[g+1]),
      .gap_o  (gap_s[g+1]),
      .best_o (best_s[g+1]),
      .rdhz_o (rdhz_s[g+1])
    );
  end

  // Form the result beat from the tail slot
  assign tail  = ctl_s[CHANNELS];
  assign found = ((tail.cmd == CMD_FIND) && tail.have) ||
                 ((tail.cmd == CMD_READ) && tail.ch_ok);

  assign m_axis_tvalid = tail.valid;

  always_comb begin
    m_axis_tdata                          = '0;
    m_axis_tdata[FOUND_LSB]               = found;
    m_axis_tdata[CHOSEN_LSB +: CHOSEN_W]  = CHOSEN_W'(best_s[CHANNELS]);
    m_axis_tdata[TOUT_LSB +: TOUT_W]      = TOUT_W'(rdhz_s[CHANNELS]);
  end

  // Time, count, gap, port and channel reach the tail only to close the chain
  assign unused_tail = ^{time_s[CHANNELS], used_s[CHANNELS], gap_s[CHANNELS],
                         tail.port, tail.chan};

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for horizon_channel_scheduler_core
// Drives find, update and read requests into the request stream and checks
// every result beat against a typed expectation or a behavioral copy of the
// per-port horizon store. It starts with a short table of directed requests,
// then runs several random phases under different channel counts, with random
// valid/ready gaps, one long output hold-off and one full drain in mid-stream.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hcs_pkg::*;

  localparam int unsigned NPORTS      = 4;
  localparam int unsigned NCHAN       = 16;
  localparam int unsigned LATENCY     = 16;
  localparam int unsigned IDLE_PCT    = 13;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 165;

  // request code that the block does not define
  localparam logic [1:0] CMD_SPARE   = 2'd3;
  // signed channel encodings: no channel, and the most negative index
  localparam logic [4:0] CH_NONE     = 5'h1F;
  localparam logic [4:0] CH_MOST_NEG = 5'h10;
  localparam logic [47:0] T_MAX      = '1;

  // request fields, last field in the low bits
  typedef struct packed {
    logic [47:0] tval;
    logic [4:0]  chan;
    logic [1:0]  port;
    logic [1:0]  cmd;
  } request_t;

  // result fields, last field in the low bits
  typedef struct packed {
    logic [47:0] horizon;
    logic [3:0]  chosen;
    logic        found;
  } grant_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_PRED,
    ROW_TYPED
  } row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [CFG_W-1:0]   cfg_val;
    request_t           req;
    grant_t             want;
  } step_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_W-1:0]      cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // behavioral copy of the block state
  logic [47:0]      horizon_model [NPORTS][NCHAN];
  logic [CFG_W-1:0] port_channels [NPORTS];
  grant_t           expected_grants [$];

  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  bit          steady_flow = 1'b0;
  bit          hold_off_req = 1'b0;

  horizon_channel_scheduler_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Apply one request to the horizon copy and return the result it yields.
  // With 16 channels a 5-bit signed index is in range exactly when it is
  // non-negative, and all four port codes are real ports.
  function automatic grant_t schedule_request(request_t r);
    grant_t      g;
    int unsigned used;
    int unsigned i;
    logic [47:0] gap;
    logic [47:0] best_gap;
    logic        have;
    g        = '0;
    have     = 1'b0;
    best_gap = '0;
    case (r.cmd)
      CMD_FIND: begin
        used = (port_channels[r.port] > NCHAN) ? NCHAN : port_channels[r.port];
        // pick the latest horizon strictly before the arrival, lowest on a tie
        for (i = 0; i < used; i++) begin
          if (r.tval > horizon_model[r.port][i]) begin
            gap = r.tval - horizon_model[r.port][i];
            if (!have || gap < best_gap) begin
              have     = 1'b1;
              best_gap = gap;
              g.chosen = 4'(i);
            end
          end
        end
        g.found = have;
      end
      CMD_UPDATE: begin
        if (!r.chan[4]) horizon_model[r.port][r.chan[3:0]] = r.tval;
      end
      CMD_READ: begin
        if (!r.chan[4]) begin
          g.found   = 1'b1;
          g.horizon = horizon_model[r.port][r.chan[3:0]];
        end
      end
      default: begin
      end
    endcase
    return g;
  endfunction

  function automatic step_row_t req_row(row_kind_e kind, logic [1:0] cmd,
                                        logic [1:0] port, logic [4:0] chan,
                                        logic [47:0] tval, logic found,
                                        logic [3:0] chosen, logic [47:0] hz);
    step_row_t row;
    row.kind         = kind;
    row.cfg_val      = '0;
    row.req.cmd      = cmd;
    row.req.port     = port;
    row.req.chan     = chan;
    row.req.tval     = tval;
    row.want.found   = found;
    row.want.chosen  = chosen;
    row.want.horizon = hz;
    return row;
  endfunction

  function automatic step_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    step_row_t row;
    row          = req_row(ROW_CFG, CMD_FIND, idx, 5'd0, 48'd0, 1'b0, 4'd0, 48'd0);
    row.cfg_val  = val;
    return row;
  endfunction

  // Mostly well-formed traffic around a moving time base, some noise.
  function automatic request_t random_request(logic [47:0] base);
    request_t    r;
    int unsigned pick;
    logic [63:0] wide;
    pick = $urandom_range(0, 99);
    if (pick < 40) r.cmd = CMD_FIND;
    else if (pick < 75) r.cmd = CMD_UPDATE;
    else if (pick < 95) r.cmd = CMD_READ;
    else r.cmd = CMD_SPARE;
    r.port = 2'($urandom_range(0, NPORTS - 1));
    if ($urandom_range(0, 9) == 0) r.chan = 5'($urandom);
    else r.chan = 5'($urandom_range(0, NCHAN - 1));
    if ($urandom_range(0, 7) == 0) begin
      wide   = {$urandom, $urandom};
      r.tval = wide[47:0];
    end else begin
      r.tval = base + 48'($urandom_range(0, 600));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("%0t result %0d: %s mismatch, got %0h want %0h",
             $realtime, results_seen, what, got, want);
  endtask

  // Offer one beat, with random idle cycles first, and hold until accepted.
  task automatic push_request(request_t r, bit typed, grant_t want);
    grant_t pred;
    @(negedge clk_i);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(r);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = schedule_request(r);
    expected_grants.push_back(typed ? want : pred);
  endtask

  // Stop offering and wait until every pending result has been seen.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    port_channels[idx] = val;
  endtask

  // Result sink: random ready, long hold-off on request, steady when asked
  always @(negedge clk_i) begin
    if (hold_off_req) begin
      hold_left    = HOLD_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (steady_flow) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Compare each result beat against the oldest pending expectation
  always @(posedge clk_i) begin
    grant_t got;
    grant_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = grant_t'(m_axis_tdata[OUT_BITS-1:0]);
      results_seen++;
      if (expected_grants.size() == 0) begin
        report_mismatch("unexpected beat", 64'(got), 64'd0);
      end else begin
        want = expected_grants.pop_front();
        if (got.found !== want.found)
          report_mismatch("found", 64'(got.found), 64'(want.found));
        if (got.chosen !== want.chosen)
          report_mismatch("chosen_channel", 64'(got.chosen), 64'(want.chosen));
        if (got.horizon !== want.horizon)
          report_mismatch("horizon_time", 64'(got.horizon), 64'(want.horizon));
      end
    end
  end

  // Watchdog: end the run when neither side moves a beat for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t no beat moved for %0d cycles", $realtime, QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    step_row_t   dir_table [$];
    step_row_t   row;
    request_t    r;
    logic [47:0] now;
    logic [63:0] wide;
    logic [CFG_W-1:0] cnt;
    int unsigned phase;
    int unsigned k;
    int unsigned p;

    for (p = 0; p < NPORTS; p++) begin
      port_channels[p] = CFG_RESET;
      for (k = 0; k < NCHAN; k++) horizon_model[p][k] = '0;
    end

    // hold reset, then release it away from the sampling edge
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: reset contents, misses, ties, extremes, odd channels
    dir_table.push_back(req_row(ROW_TYPED, CMD_READ, 2'd0, 5'd0, 48'd0, 1'b1, 4'd0, 48'd0));
    dir_table.push_back(req_row(ROW_TYPED, CMD_READ, 2'd3, 5'd15, 48'd0, 1'b1, 4'd0, 48'd0));
    dir_table.push_back(req_row(ROW_TYPED, CMD_READ, 2'd1, CH_NONE, 48'd0, 1'b0, 4'd0, 48'd0));
    dir_table.push_back(req_row(ROW_TYPED, CMD_READ, 2'd2, CH_MOST_NEG, 48'd7,
                                1'b0, 4'd0, 48'd0));
    // arrival equal to every horizon: nothing qualifies
    dir_table.push_back(req_row(ROW_TYPED, CMD_FIND, 2'd0, 5'd0, 48'd0, 1'b0, 4'd0, 48'd0));
    // all horizons tie at zero: lowest index wins
    dir_table.push_back(req_row(ROW_TYPED, CMD_FIND, 2'd0, 5'd0, 48'd1, 1'b1, 4'd0, 48'd0));
    dir_table.push_back(req_row(ROW_TYPED, CMD_UPDATE, 2'd0, 5'd3, 48'd100,
                                1'b0, 4'd0, 48'd0));
    dir_table.push_back(req_row(ROW_TYPED, CMD_UPDATE, 2'd0, 5'd7, 48'd150,
                                1'b0, 4'd0, 48'd0));
    // update to no channel is dropped
    dir_table.push_back(req_row(ROW_TYPED, CMD_UPDATE, 2'd0, CH_NONE, 48'd5,
                                1'b0, 4'd0, 48'd0));
    dir_table.push_back(req_row(ROW_PRED, CMD_FIND, 2'd0, 5'd0, 48'd151, 1'b0, 4'd0, 48'd0));
    dir_table.push_back(req_row(ROW_PRED, CMD_FIND, 2'd0, 5'd0, 48'd150, 1'b0, 4'd0, 48'd0));
    dir_table.push_back(req_row(ROW_TYPED, CMD_UPDATE, 2'd1, 5'd5, 48'd200,
                                1'b0, 4'd0, 48'd0));
    dir_table.push_back(req_row(ROW_TYPED, CMD_UPDATE, 2'd1, 5'd9, 48'd200,
                                1'b0, 4'd0, 48'd0));
    dir_table.push_back(req_row(ROW_TYPED, CMD_READ, 2'd1, 5'd9, 48'd0, 1'b1, 4'd0, 48'd200));
    dir_table.push_back(req_row(ROW_PRED, CMD_FIND, 2'd1, 5'd0, 48'd300, 1'b0, 4'd0, 48'd0));
    dir_table.push_back(req_row(ROW_TYPED, CMD_UPDATE, 2'd3, 5'd15, T_MAX, 1'b0, 4'd0, 48'd0));
    dir_table.push_back(req_row(ROW_TYPED, CMD_READ, 2'd3, 5'd15, 48'd0, 1'b1, 4'd0, T_MAX));
    dir_table.push_back(req_row(ROW_PRED, CMD_FIND, 2'd3, 5'd0, T_MAX, 1'b0, 4'd0, 48'd0));
    dir_table.push_back(req_row(ROW_TYPED, CMD_SPARE, 2'd2, 5'd2, T_MAX, 1'b0, 4'd0, 48'd0));
    dir_table.push_back(req_row(ROW_TYPED, CMD_READ, 2'd2, CH_NONE, T_MAX, 1'b0, 4'd0, 48'd0));
    dir_table.push_back(req_row(ROW_TYPED, CMD_UPDATE, 2'd2, 5'd0, 48'h8000_0000_0000,
                                1'b0, 4'd0, 48'd0));
    dir_table.push_back(req_row(ROW_PRED, CMD_FIND, 2'd2, 5'd0, T_MAX, 1'b0, 4'd0, 48'd0));
    // no channels in use: every find misses
    dir_table.push_back(cfg_row(2'd1, 5'd0));
    dir_table.push_back(req_row(ROW_TYPED, CMD_FIND, 2'd1, 5'd0, T_MAX, 1'b0, 4'd0, 48'd0));
    // count above the channel total acts as all channels
    dir_table.push_back(cfg_row(2'd1, 5'd31));
    dir_table.push_back(req_row(ROW_TYPED, CMD_UPDATE, 2'd1, 5'd15, 48'd299,
                                1'b0, 4'd0, 48'd0));
    dir_table.push_back(req_row(ROW_PRED, CMD_FIND, 2'd1, 5'd0, 48'd300, 1'b0, 4'd0, 48'd0));
    dir_table.push_back(cfg_row(2'd1, 5'd2));
    dir_table.push_back(req_row(ROW_PRED, CMD_FIND, 2'd1, 5'd0, 48'd300, 1'b0, 4'd0, 48'd0));

    foreach (dir_table[i]) begin
      row = dir_table[i];
      if (row.kind == ROW_CFG) begin
        drain_results();
        write_count(row.req.port, row.cfg_val);
      end else begin
        push_request(row.req, row.kind == ROW_TYPED, row.want);
      end
    end

    // Random phases, each under its own set of channel counts
    for (phase = 0; phase < PHASES; phase++) begin
      drain_results();
      for (p = 0; p < NPORTS; p++) begin
        case (phase)
          0: cnt = 5'd16;
          1: cnt = (p == 0) ? 5'd0 : (p == 1) ? 5'd1 : (p == 2) ? 5'd31 : 5'd17;
          2: cnt = (p == 0) ? 5'd15 : (p == 1) ? 5'd16 : (p == 2) ? 5'd0 : 5'd2;
          default: cnt = ($urandom_range(0, 3) == 0) ? 5'd16 : 5'($urandom_range(0, 31));
        endcase
        write_count(2'(p), cnt);
      end
      steady_flow = (phase == 1);
      // one phase runs its time base across the wrap point
      if (phase == 5) begin
        now = T_MAX - 48'd2000;
      end else begin
        wide = {$urandom, $urandom};
        now  = wide[47:0];
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (phase == 3 && k == 40) hold_off_req = 1'b1;
        if (phase == 4 && k == 80) drain_results();
        now = now + 48'($urandom_range(0, 48));
        r = random_request(now);
        push_request(r, 1'b0, '0);
      end
    end

    steady_flow = 1'b0;
    drain_results();
    repeat (2 * LATENCY) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
